// ----- hdl/esd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  // fixed field widths of the ports
  localparam int SAMPLE_IN_W  = 16;
  localparam int MEAN_W       = 24;
  localparam int DEV_W        = 24;
  localparam int POS_OUT_W    = 12;

  // configuration port
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int TRIAL_CFG_W  = 9;
  localparam int LENGTH_CFG_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_TRIAL_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'd1;

  localparam int TRIAL_COUNT_RST  = 1;
  localparam int BLOCK_LENGTH_RST = 4096;

  // per-sample control that follows a word from the counters to the result
  typedef struct packed {
    logic                 first_trial;
    logic                 last_trial;
    logic                 last_pos;
    logic [POS_OUT_W-1:0] position;
  } esd_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/esd_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module esd_store
  import esd_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int PW    = 12,
  parameter int SB    = 16,
  parameter int TB    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // accepted sample
  input  wire logic                 acc_i,
  input  wire logic signed [SB-1:0] acc_x,
  input  wire logic [PW-1:0]        acc_pos,
  input  wire esd_ctl_t             acc_ctl,
  // updated sums of a final-trial sample
  output logic                      job_valid,
  output esd_ctl_t                  job_ctl,
  output logic signed [SB+TB-1:0]   job_s,
  output logic [2*SB-2+TB:0]        job_q
);

  localparam int SW  = SB + TB;
  localparam int QW  = 2 * SB - 1 + TB;
  localparam int SQW = 2 * SB - 1;
  localparam int MW  = SW + QW;

  // sum and sum of squares share one word per position
  logic [MW-1:0] mem [DEPTH];

  logic                 s1_valid_r;
  esd_ctl_t             s1_ctl_r;
  logic signed [SB-1:0] s1_x_r;
  logic [SQW-1:0]       s1_sq_r;
  logic [PW-1:0]        s1_pos_r;
  logic [MW-1:0]        rd_r;
  logic                 fwd_r;
  logic [MW-1:0]        fwd_data_r;

  logic signed [2*SB-1:0] sq_full;
  logic [SQW-1:0]         sq_in;
  logic [MW-1:0]          base;
  logic signed [SW-1:0]   base_s;
  logic [QW-1:0]          base_q;
  logic signed [SW-1:0]   x_ext;
  logic [QW-1:0]          sq_ext;
  logic signed [SW-1:0]   s_new;
  logic [QW-1:0]          q_new;
  logic [MW-1:0]          wr_data;

  // square of the incoming sample, registered with it
  assign sq_full = acc_x * acc_x;
  assign sq_in   = sq_full[SQW-1:0];

  // modify: previous word's write lands on the edge this read was taken
  assign base   = fwd_r ? fwd_data_r : rd_r;
  assign base_s = $signed(base[MW-1:QW]);
  assign base_q = base[QW-1:0];
  assign x_ext  = {{(SW-SB){s1_x_r[SB-1]}}, s1_x_r};
  assign sq_ext = {{(QW-SQW){1'b0}}, s1_sq_r};
  assign s_new  = s1_ctl_r.first_trial ? x_ext  : base_s + x_ext;
  assign q_new  = s1_ctl_r.first_trial ? sq_ext : base_q + sq_ext;
  assign wr_data = {s_new, q_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc_i;
    end
  end

  // read on accept, write back in the cycle after
  always_ff @(posedge clk) begin
    if (acc_i) begin
      rd_r       <= mem[acc_pos];
      fwd_r      <= s1_valid_r && (s1_pos_r == acc_pos);
      fwd_data_r <= wr_data;
      s1_ctl_r   <= acc_ctl;
      s1_x_r     <= acc_x;
      s1_sq_r    <= sq_in;
      s1_pos_r   <= acc_pos;
    end
    if (s1_valid_r) begin
      mem[s1_pos_r] <= wr_data;
    end
  end

  assign job_valid = s1_valid_r && s1_ctl_r.last_trial;
  assign job_ctl   = s1_ctl_r;
  assign job_s     = s_new;
  assign job_q     = q_new;

endmodule

`default_nettype wire

// ----- hdl/esd_math.sv -----
`timescale 1ns / 1ps
`default_nettype none

module esd_math
  import esd_pkg::*;
#(
  parameter int SW = 24,
  parameter int QW = 39,
  parameter int NB = 9
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 job_valid,
  input  wire esd_ctl_t             job_ctl,
  input  wire logic signed [SW-1:0] job_s,
  input  wire logic [QW-1:0]        job_q,
  input  wire logic [NB-1:0]        n_i,
  output logic                      idle_o,
  output logic                      res_valid,
  input  wire logic                 res_take,
  output logic [MEAN_W-1:0]         res_mean,
  output logic [DEV_W-1:0]          res_dev,
  output esd_ctl_t                  res_ctl
);

  localparam int DW  = 2 * SW;
  localparam int RW  = DW + 16;
  localparam int RTW = RW / 2;
  localparam int AW  = SW + 9;
  localparam int QDW = (AW > RTW) ? AW : RTW;
  localparam int CW  = $clog2(QDW);
  localparam int MXW = (QDW + 1 > MEAN_W) ? QDW + 1 : MEAN_W;
  localparam int DXW = (QDW > DEV_W) ? QDW : DEV_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUB, ST_ROOT, ST_DIV, ST_DONE
  } state_t;

  state_t               state_r;
  logic [CW-1:0]        cnt_r;
  esd_ctl_t             ctl_r;
  logic signed [SW-1:0] s_r;
  logic [QW-1:0]        q_r;
  logic [DW-1:0]        nq_r;
  logic [DW-1:0]        ss_r;
  logic                 neg_r;
  logic [RW-1:0]        rad_r;
  logic [RTW:0]         rrem_r;
  logic [RTW-1:0]       root_r;
  logic [QDW-1:0]       mq_r;
  logic [NB-1:0]        mrem_r;
  logic [QDW-1:0]       dq_r;
  logic [NB-1:0]        drem_r;

  // one restoring division step: remainder in the upper bits, quotient below
  function automatic logic [NB+QDW-1:0] div_step(input logic [NB-1:0]  rem,
                                                 input logic [QDW-1:0] quo,
                                                 input logic [NB-1:0]  dvs);
    logic [NB:0] t;
    logic [NB:0] d;
    logic        ge;
    t  = {rem, quo[QDW-1]};
    d  = t - {1'b0, dvs};
    ge = (t >= {1'b0, dvs});
    return {(ge ? d[NB-1:0] : t[NB-1:0]), quo[QDW-2:0], ge};
  endfunction

  logic signed [DW-1:0] ss_full;
  logic [DW-1:0]        nq_full;
  logic [AW-1:0]        a_ext;
  logic [AW-1:0]        n_ext;
  logic [AW-1:0]        mag;
  logic [RTW+2:0]       rt_t;
  logic [RTW+2:0]       rt_trial;
  logic [RTW+2:0]       rt_diff;
  logic                 rt_ge;
  logic [RTW:0]         rrem_nxt;
  logic [RTW-1:0]       root_nxt;
  logic [NB+QDW-1:0]    mdiv_nxt;
  logic [NB+QDW-1:0]    ddiv_nxt;
  logic [MXW-1:0]       mq_ext;
  logic [MXW-1:0]       mean_full;
  logic [DXW-1:0]       dev_full;

  // products for the radicand N*Q - S*S
  assign ss_full = s_r * s_r;
  assign nq_full = DW'(n_i) * DW'(q_r);

  // floored mean: for negative sums divide |256*S| + N - 1 and negate
  assign a_ext = {s_r[SW-1], s_r, 8'b0};
  assign n_ext = AW'(n_i);
  assign mag   = s_r[SW-1] ? (~a_ext + n_ext) : a_ext;

  // two radicand bits per root step
  assign rt_t     = {rrem_r, rad_r[RW-1 -: 2]};
  assign rt_trial = {1'b0, root_r, 2'b01};
  assign rt_diff  = rt_t - rt_trial;
  assign rt_ge    = (rt_t >= rt_trial);
  assign rrem_nxt = rt_ge ? rt_diff[RTW:0] : rt_t[RTW:0];
  assign root_nxt = {root_r[RTW-2:0], rt_ge};

  assign mdiv_nxt = div_step(mrem_r, mq_r, n_i);
  assign ddiv_nxt = div_step(drem_r, dq_r, n_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            s_r     <= job_s;
            q_r     <= job_q;
            ctl_r   <= job_ctl;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          nq_r    <= nq_full;
          ss_r    <= $unsigned(ss_full);
          neg_r   <= s_r[SW-1];
          mq_r    <= QDW'(mag);
          mrem_r  <= '0;
          state_r <= ST_SUB;
        end
        ST_SUB: begin
          rad_r   <= {nq_r - ss_r, 16'b0};
          rrem_r  <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          rad_r  <= {rad_r[RW-3:0], 2'b00};
          rrem_r <= rrem_nxt;
          root_r <= root_nxt;
          if (cnt_r == CW'(RTW - 1)) begin
            dq_r    <= QDW'(root_nxt);
            drem_r  <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DIV: begin
          mrem_r <= mdiv_nxt[NB+QDW-1:QDW];
          mq_r   <= mdiv_nxt[QDW-1:0];
          drem_r <= ddiv_nxt[NB+QDW-1:QDW];
          dq_r   <= ddiv_nxt[QDW-1:0];
          if (cnt_r == CW'(QDW - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // result words, low bits kept
  assign mq_ext    = MXW'(mq_r);
  assign mean_full = neg_r ? (~mq_ext + 1'b1) : mq_ext;
  assign dev_full  = DXW'(dq_r);

  assign idle_o    = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res_mean  = mean_full[MEAN_W-1:0];
  assign res_dev   = dev_full[DEV_W-1:0];
  assign res_ctl   = ctl_r;

endmodule

`default_nettype wire

// ----- hdl/ensemble_mean_stddev_core.sv -----
// Channel  Handshake           Word
// -------  ------------------  ------------------------------------------------
// in       in_valid/in_stall   in_sample_value
// out      out_valid/out_stall out_mean_value, out_deviation_value,
//                              out_sample_position, out_last_of_block
// cfg      cfg_wen             cfg_index, cfg_wdata (no wait, no read-back)
//
// Samples of every trial but the last are accepted back to back while the
// result unit is idle: read on accept, add and write back the next cycle,
// with a bypass for back-to-back hits. A sample of the last trial stalls
// input while the result unit runs 32 root and 33 divider steps (defaults).
// Reset clears counters and control only; the sum memory needs no clearing.
// A result waiting on out_stall holds in the output register while the
// next sample is read and updated.
`timescale 1ns / 1ps
`default_nettype none

module ensemble_mean_stddev_core
  import esd_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_TRIALS  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [SAMPLE_IN_W-1:0] in_sample_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [MEAN_W-1:0]         out_mean_value,
  output logic [DEV_W-1:0]                 out_deviation_value,
  output logic [POS_OUT_W-1:0]             out_sample_position,
  output logic                             out_last_of_block,
  input  wire logic                        cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int PW   = $clog2(MAX_SAMPLES);
  localparam int TB   = $clog2(MAX_TRIALS);
  localparam int NB   = $clog2(MAX_TRIALS + 1);
  localparam int SW   = SAMPLE_BITS + TB;
  localparam int QW   = 2 * SAMPLE_BITS - 1 + TB;
  localparam int IW   = (SAMPLE_BITS > SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
  localparam int TCW  = (NB > TRIAL_CFG_W) ? NB : TRIAL_CFG_W;
  localparam int LNB  = $clog2(MAX_SAMPLES + 1);
  localparam int LCW  = (LNB > LENGTH_CFG_W) ? LNB : LENGTH_CFG_W;
  localparam int POSX = (PW > POS_OUT_W) ? PW : POS_OUT_W;
  localparam int RST_LEN = (MAX_SAMPLES < BLOCK_LENGTH_RST) ? MAX_SAMPLES
                                                            : BLOCK_LENGTH_RST;

  // clamped configuration
  logic [NB-1:0] n_r, n_nxt;
  logic [TB-1:0] n_last_r, n_last_nxt;
  logic [PW-1:0] len_last_r, len_last_nxt;
  logic [TCW-1:0] tc_w, tc_clamp;
  logic [LCW-1:0] bl_w, bl_clamp;

  // counters
  logic [PW-1:0] pos_r, pos_nxt;
  logic [TB-1:0] trial_r, trial_nxt;
  logic          last_pos, last_trial, in_acc;
  logic [PW-1:0] pos_eff;
  logic [POSX-1:0] pos_x;
  esd_ctl_t      acc_ctl;

  // sample as a SAMPLE_BITS-wide two's complement number
  logic [IW-1:0]                 in_ext;
  logic signed [SAMPLE_BITS-1:0] x;

  // store and result unit links
  logic              job_valid;
  esd_ctl_t          job_ctl;
  logic signed [SW-1:0] job_s;
  logic [QW-1:0]     job_q;
  logic              math_idle;
  logic              res_valid, res_take;
  logic [MEAN_W-1:0] res_mean;
  logic [DEV_W-1:0]  res_dev;
  esd_ctl_t          res_ctl;

  // output register
  logic              out_valid_r;
  logic [MEAN_W-1:0] mean_r;
  logic [DEV_W-1:0]  dev_r;
  logic [POS_OUT_W-1:0] opos_r;
  logic              olast_r;

  // config writes, clamped on the way in
  assign tc_w = TCW'(cfg_wdata[TRIAL_CFG_W-1:0]);
  assign bl_w = LCW'(cfg_wdata[LENGTH_CFG_W-1:0]);

  always_comb begin
    if (tc_w == '0) begin
      tc_clamp = TCW'(1);
    end else if (tc_w > TCW'(MAX_TRIALS)) begin
      tc_clamp = TCW'(MAX_TRIALS);
    end else begin
      tc_clamp = tc_w;
    end
    if (bl_w == '0) begin
      bl_clamp = LCW'(1);
    end else if (bl_w > LCW'(MAX_SAMPLES)) begin
      bl_clamp = LCW'(MAX_SAMPLES);
    end else begin
      bl_clamp = bl_w;
    end
  end

  always_comb begin
    n_nxt        = n_r;
    n_last_nxt   = n_last_r;
    len_last_nxt = len_last_r;
    if (cfg_wen) begin
      case (cfg_index)
        REG_TRIAL_COUNT: begin
          n_nxt      = NB'(tc_clamp);
          n_last_nxt = TB'(tc_clamp - 1'b1);
        end
        REG_BLOCK_LENGTH: begin
          len_last_nxt = PW'(bl_clamp - 1'b1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r        <= NB'(TRIAL_COUNT_RST);
      n_last_r   <= TB'(TRIAL_COUNT_RST - 1);
      len_last_r <= PW'(RST_LEN - 1);
    end else begin
      n_r        <= n_nxt;
      n_last_r   <= n_last_nxt;
      len_last_r <= len_last_nxt;
    end
  end

  // position and trial tracking; a counter past its end counts as the end
  assign in_stall   = job_valid || !math_idle;
  assign in_acc     = in_valid && !in_stall;
  assign last_pos   = (pos_r >= len_last_r);
  assign last_trial = (trial_r >= n_last_r);
  assign pos_eff    = last_pos ? len_last_r : pos_r;
  assign pos_x      = POSX'(pos_eff);

  assign acc_ctl.first_trial = (trial_r == '0);
  assign acc_ctl.last_trial  = last_trial;
  assign acc_ctl.last_pos    = last_pos;
  assign acc_ctl.position    = pos_x[POS_OUT_W-1:0];

  always_comb begin
    pos_nxt   = pos_r;
    trial_nxt = trial_r;
    if (in_acc) begin
      if (last_pos) begin
        pos_nxt   = '0;
        trial_nxt = last_trial ? '0 : trial_r + 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      trial_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      trial_r <= trial_nxt;
    end
  end

  assign in_ext = IW'($unsigned(in_sample_value));
  assign x      = $signed(in_ext[SAMPLE_BITS-1:0]);

  esd_store #(
    .DEPTH (MAX_SAMPLES),
    .PW    (PW),
    .SB    (SAMPLE_BITS),
    .TB    (TB)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_i     (in_acc),
    .acc_x     (x),
    .acc_pos   (pos_eff),
    .acc_ctl   (acc_ctl),
    .job_valid (job_valid),
    .job_ctl   (job_ctl),
    .job_s     (job_s),
    .job_q     (job_q)
  );

  esd_math #(
    .SW (SW),
    .QW (QW),
    .NB (NB)
  ) u_math (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ctl   (job_ctl),
    .job_s     (job_s),
    .job_q     (job_q),
    .n_i       (n_r),
    .idle_o    (math_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_mean  (res_mean),
    .res_dev   (res_dev),
    .res_ctl   (res_ctl)
  );

  // output register: loads when empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      mean_r  <= res_mean;
      dev_r   <= res_dev;
      opos_r  <= res_ctl.position;
      olast_r <= res_ctl.last_pos;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mean_value      = $signed(mean_r);
  assign out_deviation_value = dev_r;
  assign out_sample_position = opos_r;
  assign out_last_of_block   = olast_r;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import esd_pkg::*;

  localparam int MAX_LEN     = 4096;
  localparam int MAX_N       = 256;
  // a last-trial word passes through root and divider
  localparam int SETTLE      = 100;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RAND_WORDS  = 600;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    logic signed [MEAN_W-1:0] mean_value;
    logic [DEV_W-1:0]         deviation_value;
    logic [POS_OUT_W-1:0]     sample_position;
    logic                     last_of_block;
  } stats_word_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_IN_W-1:0] in_sample_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [MEAN_W-1:0]      out_mean_value;
  logic [DEV_W-1:0]              out_deviation_value;
  logic [POS_OUT_W-1:0]          out_sample_position;
  logic                          out_last_of_block;
  logic                          cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata = '0;

  // predicted block state
  logic [TRIAL_CFG_W-1:0]  trial_reg  = TRIAL_CFG_W'(TRIAL_COUNT_RST);
  logic [LENGTH_CFG_W-1:0] length_reg = LENGTH_CFG_W'(BLOCK_LENGTH_RST);
  int                      pos_cnt    = 0;
  int                      trial_idx  = 0;
  longint                  sum_mem [MAX_LEN];
  longint unsigned         sq_mem  [MAX_LEN];
  stats_word_t             pending_stats [$];
  stats_word_t             head_stats;

  // stimulus and bookkeeping
  int          error_count = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  bit          gaps_on = 1'b1;
  int          burst_left = 4;
  bit          data_near_base = 1'b0;
  logic [15:0] base_value = '0;
  stall_mode_t stall_mode = STALL_RANDOM;
  int          hold_req = 0;
  int          hold_left = 0;
  int          stall_phase = 0;

  ensemble_mean_stddev_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mean_value      (out_mean_value),
    .out_deviation_value (out_deviation_value),
    .out_sample_position (out_sample_position),
    .out_last_of_block   (out_last_of_block),
    .cfg_wen             (cfg_wen),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall pattern, with long hold-offs on request
  always @(posedge clk) begin
    stall_phase++;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= ((stall_phase % 9) < 4);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_stats.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word at position %0d", $time, out_sample_position);
      end else begin
        head_stats = pending_stats.pop_front();
        if (out_mean_value !== head_stats.mean_value) begin
          error_count++;
          $display("%0t: mean_value expected %0d, actual %0d", $time,
                   head_stats.mean_value, out_mean_value);
        end
        if (out_deviation_value !== head_stats.deviation_value) begin
          error_count++;
          $display("%0t: deviation_value expected %0d, actual %0d", $time,
                   head_stats.deviation_value, out_deviation_value);
        end
        if (out_sample_position !== head_stats.sample_position) begin
          error_count++;
          $display("%0t: sample_position expected %0d, actual %0d", $time,
                   head_stats.sample_position, out_sample_position);
        end
        if (out_last_of_block !== head_stats.last_of_block) begin
          error_count++;
          $display("%0t: last_of_block expected %0b, actual %0b", $time,
                   head_stats.last_of_block, out_last_of_block);
        end
      end
    end
  end

  // register value as the block uses it: 0 acts as 1, above the max acts as the max
  function automatic int clamp_cfg(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // update per-position sums and predict the stats word, if any
  function automatic void accumulate_sample(input logic signed [SAMPLE_IN_W-1:0] value);
    int              n;
    int              len;
    int              pos;
    bit              last_pos;
    bit              last_trial;
    longint          x;
    longint          s;
    longint          a;
    longint          m;
    longint unsigned q;
    longint unsigned d;
    longint unsigned dev;
    stats_word_t     w;
    n          = clamp_cfg(int'(trial_reg), MAX_N);
    len        = clamp_cfg(int'(length_reg), MAX_LEN);
    x          = longint'(value);
    last_pos   = (pos_cnt >= len - 1);
    last_trial = (trial_idx >= n - 1);
    pos        = last_pos ? len - 1 : pos_cnt;
    if (trial_idx == 0) begin
      sum_mem[pos] = x;
      sq_mem[pos]  = x * x;
    end else begin
      sum_mem[pos] += x;
      sq_mem[pos]  += x * x;
    end
    if (last_trial) begin
      s = sum_mem[pos];
      q = sq_mem[pos];
      // floored mean in Q.8
      a = s * 256;
      m = a / n;
      if ((a % n) != 0 && a < 0) m--;
      d   = longint'(unsigned'(n)) * q - longint'(unsigned'(s * s));
      dev = int_sqrt(d * 64'd65536) / longint'(unsigned'(n));
      w.mean_value      = m[MEAN_W-1:0];
      w.deviation_value = dev[DEV_W-1:0];
      w.sample_position = pos[POS_OUT_W-1:0];
      w.last_of_block   = last_pos;
      pending_stats = {pending_stats, w};
    end
    if (last_pos) begin
      pos_cnt   = 0;
      trial_idx = last_trial ? 0 : trial_idx + 1;
    end else begin
      pos_cnt++;
    end
  endfunction

  // offer one sample word; returns at the edge it is accepted or after a gap
  task automatic send_word(input logic signed [SAMPLE_IN_W-1:0] value);
    in_valid        <= 1'b1;
    in_sample_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    accumulate_sample(value);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 20);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // stop sending, let every predicted word come out, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // writes both registers, trial count first
  task automatic write_regs(input logic [CFG_DATA_W-1:0] trials_word,
                            input logic [CFG_DATA_W-1:0] length_word);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_TRIAL_COUNT;
    cfg_wdata <= trials_word;
    @(posedge clk);
    trial_reg  = trials_word[TRIAL_CFG_W-1:0];
    cfg_index <= REG_BLOCK_LENGTH;
    cfg_wdata <= length_word;
    @(posedge clk);
    length_reg = length_word[LENGTH_CFG_W-1:0];
    cfg_wen   <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_IN_W-1:0] next_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3, 4:    if (data_near_base) return base_value + 16'(r[3:0]) - 16'd8;
               else return r[15:0];
      default: return r[15:0];
    endcase
  endfunction

  // reset values: one trial, 4096 positions, so every word gives a result
  task automatic test_reset_defaults();
    send_word(16'sh8000);
    send_word(16'sh7FFF);
    send_word('0);
    send_word(-16'sd1);
    send_word(16'sh5A5A);
    wait_idle();
  endtask

  // block length cut below the current position: next word is the last one
  task automatic test_length_cut();
    write_regs(13'd1, 13'd3);
    send_word(16'sd1);
    send_word(-16'sd2);
    send_word(16'sd3);
    send_word(-16'sd4);
    wait_idle();
  endtask

  // zero and oversized register values, upper data bits ignored,
  // trial count lowered mid-ensemble
  task automatic test_register_clamp();
    write_regs(13'd0, 13'd0);
    send_word(16'sd100);
    send_word(-16'sd100);
    wait_idle();
    write_regs(13'h1FFF, 13'd2);
    repeat (3) begin
      send_word(16'sh8000);
      send_word(16'sh7FFF);
    end
    wait_idle();
    write_regs(13'd2, 13'd2);
    send_word(16'sh7FFF);
    send_word(16'sh8000);
    wait_idle();
  endtask

  // negative mean must floor, and full-scale spread
  task automatic test_floor_and_spread();
    write_regs(13'd3, 13'd1);
    send_word(-16'sd1);
    send_word('0);
    send_word('0);
    wait_idle();
    write_regs(13'd2, 13'd2);
    send_word(16'sh8000);
    send_word(16'sh7FFF);
    send_word(16'sh7FFF);
    send_word(16'sh8000);
    wait_idle();
  endtask

  // receiver holds off long enough for the block to stall its input,
  // then the sender waits for every word to drain
  task automatic test_backpressure();
    write_regs(13'd1, 13'd16);
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    hold_req   = 600;
    repeat (16) send_word(next_sample());
    wait_idle();
    gaps_on    = 1'b1;
    stall_mode = STALL_RANDOM;
  endtask

  task automatic test_random();
    int                    sent;
    int                    ens;
    int                    words;
    logic [CFG_DATA_W-1:0] trials_word;
    logic [CFG_DATA_W-1:0] length_word;
    sent = 0;
    while (sent < RAND_WORDS) begin
      wait_idle();
      trials_word = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 15))
        0:       trials_word[TRIAL_CFG_W-1:0] = '0;
        1:       trials_word[TRIAL_CFG_W-1:0] = TRIAL_CFG_W'(MAX_N);
        2:       trials_word[TRIAL_CFG_W-1:0] = TRIAL_CFG_W'($urandom_range(MAX_N + 1, 511));
        3:       trials_word[TRIAL_CFG_W-1:0] = TRIAL_CFG_W'($urandom_range(7, 40));
        default: trials_word[TRIAL_CFG_W-1:0] = TRIAL_CFG_W'($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 15))
        0:       length_word = '0;
        1:       length_word = CFG_DATA_W'(MAX_LEN);
        2:       length_word = CFG_DATA_W'($urandom_range(MAX_LEN + 1, 8191));
        3:       length_word = CFG_DATA_W'($urandom_range(17, 64));
        default: length_word = CFG_DATA_W'($urandom_range(1, 12));
      endcase
      // past the first trial, a longer block would read sums never written
      if (trial_idx != 0 && clamp_cfg(int'(length_word), MAX_LEN) >
                            clamp_cfg(int'(length_reg), MAX_LEN))
        length_word = length_reg;
      write_regs(trials_word, length_word);

      ens = clamp_cfg(int'(trial_reg), MAX_N) * clamp_cfg(int'(length_reg), MAX_LEN);
      if (ens <= 40) words = ens * $urandom_range(1, 4);
      else if (ens <= 300) words = ens;
      else words = $urandom_range(10, 50);

      gaps_on        = ($urandom_range(0, 2) != 0);
      stall_mode     = stall_mode_t'($urandom_range(0, 2));
      data_near_base = 1'($urandom_range(0, 1));
      base_value     = 16'($urandom);
      repeat (words) begin
        send_word(next_sample());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_length_cut();
    test_register_clamp();
    test_floor_and_spread();
    test_backpressure();
    test_random();
    wait_idle();
    if (pending_stats.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
